### rtl/grc_pkg.sv
// Shared types and constants for the graph reachability counter.
// Depends on nothing; every rtl module imports it.
`default_nettype none
package grc_pkg;

    localparam int NODES     = 256;
    localparam int ID_W      = 8;
    localparam int CMD_W     = 2;
    localparam int COUNT_W   = 16;
    localparam int SRC_CNT_W = 9;

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    // two-level find-first over the pending set: group, then bit in group
    localparam int GRP_SIZE = 16;
    localparam int BW       = $clog2(GRP_SIZE);
    localparam int NGRP     = (NODES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GW       = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PW       = NGRP * GRP_SIZE;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_REACH   = 2'd2,
        CMD_CLOSURE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_E_WRITE,
        S_R_GRP,
        S_R_POP,
        S_R_MERGE,
        S_C_READ,
        S_C_CHECK
    } t_state;

    typedef struct packed {
        logic          init;
        logic [NW-1:0] init_node;
        logic          grp;
        logic          pop;
        logic          merge;
    } t_front_ctl;

    typedef struct packed {
        logic          empty;
        logic [NW-1:0] node;
    } t_front_sts;

endpackage
`default_nettype wire

### rtl/graph_reachability_counter.sv
// Top level of the graph reachability counter: command sequencer, counters
// and result register. Uses grc_pkg, grc_adj_mem and grc_frontier.
// Edge add/remove: the row is updated in S_E_WRITE, then o_valid strobes.
// Reach query: a pick / row read / merge loop per node reached (source
//   included), around the single adjacency read port.
// Closure: each node's row is scanned, plus one reach walk per node with
//   out-edges. Out-of-range queries raise o_valid the cycle after start.
// Synchronous active-low reset empties the graph at once and clears the
// reverse register; results are strobed for one cycle and cannot be stalled.
`default_nettype none
module graph_reachability_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [grc_pkg::CMD_W-1:0]     i_command,
    input  wire logic [grc_pkg::ID_W-1:0]      i_from_node,
    input  wire logic [grc_pkg::ID_W-1:0]      i_to_node,
    output logic                               o_valid,
    output logic      [grc_pkg::COUNT_W-1:0]   o_count,
    output logic      [grc_pkg::SRC_CNT_W-1:0] o_sources_counted
);
    import grc_pkg::*;

    t_state               r_state, n_state;
    logic                 r_reverse;
    logic                 r_closure, n_closure;
    logic                 r_add, n_add;
    logic [NW-1:0]        r_src, n_src;
    logic [NW-1:0]        r_dst, n_dst;
    logic [NW-1:0]        r_v, n_v;
    logic [CW-1:0]        r_pops, n_pops;
    logic [COUNT_W-1:0]   r_sum, n_sum;
    logic [SRC_CNT_W-1:0] r_tally, n_tally;
    logic                 r_valid, n_valid;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [SRC_CNT_W-1:0] r_sources, n_sources;

    t_front_ctl           w_ctl;
    t_front_sts           w_sts;
    logic [NODES-1:0]     w_row;
    logic [NODES-1:0]     w_wdata;
    logic                 w_wr_en;
    logic [NW-1:0]        w_rd_addr;
    logic [ID_W-1:0]      w_esrc, w_edst;
    logic                 w_edge_ok, w_from_ok;
    logic [CW-1:0]        w_reach;
    logic [COUNT_W:0]     w_sum_wide;
    logic                 w_adv;

    grc_adj_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_src),
        .i_wr_data (w_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_row  (w_row)
    );

    grc_frontier u_front (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_row (w_row),
        .o_sts (w_sts)
    );

    assign w_esrc    = r_reverse ? i_to_node : i_from_node;
    assign w_edst    = r_reverse ? i_from_node : i_to_node;
    assign w_edge_ok = (32'(w_esrc) < NODES) && (32'(w_edst) < NODES);
    assign w_from_ok = 32'(i_from_node) < NODES;

    // source is popped once too, so drop it from the tally
    assign w_reach    = r_pops - CW'(1);
    assign w_sum_wide = {1'b0, r_sum} + (COUNT_W + 1)'(w_reach);

    always_comb begin
        w_wdata        = w_row;
        w_wdata[r_dst] = r_add;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_count           = r_count;
    assign o_sources_counted = r_sources;

    always_comb begin
        n_state   = r_state;
        n_closure = r_closure;
        n_add     = r_add;
        n_src     = r_src;
        n_dst     = r_dst;
        n_v       = r_v;
        n_pops    = r_pops;
        n_sum     = r_sum;
        n_tally   = r_tally;
        n_valid   = 1'b0;
        n_count   = r_count;
        n_sources = r_sources;
        w_ctl     = '0;
        w_wr_en   = 1'b0;
        w_rd_addr = r_v;
        w_adv     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_cmd'(i_command))
                        CMD_ADD, CMD_REMOVE: begin
                            n_add     = (t_cmd'(i_command) == CMD_ADD);
                            n_src     = NW'(w_esrc);
                            n_dst     = NW'(w_edst);
                            w_rd_addr = NW'(w_esrc);
                            if (w_edge_ok) begin
                                n_state = S_E_WRITE;
                            end else begin
                                n_valid   = 1'b1;
                                n_count   = '0;
                                n_sources = '0;
                            end
                        end
                        CMD_REACH: begin
                            if (w_from_ok) begin
                                w_ctl.init      = 1'b1;
                                w_ctl.init_node = NW'(i_from_node);
                                n_pops          = '0;
                                n_closure       = 1'b0;
                                n_state         = S_R_GRP;
                            end else begin
                                n_valid   = 1'b1;
                                n_count   = '0;
                                n_sources = '0;
                            end
                        end
                        CMD_CLOSURE: begin
                            n_closure = 1'b1;
                            n_sum     = '0;
                            n_tally   = '0;
                            n_v       = '0;
                            n_state   = S_C_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_E_WRITE: begin
                w_wr_en   = 1'b1;
                n_valid   = 1'b1;
                n_count   = '0;
                n_sources = '0;
                n_state   = S_IDLE;
            end
            S_R_GRP: begin
                if (w_sts.empty) begin
                    if (r_closure) begin
                        n_sum = w_sum_wide[COUNT_W] ? '1 : w_sum_wide[COUNT_W-1:0];
                        if (r_tally != '1) begin
                            n_tally = r_tally + SRC_CNT_W'(1);
                        end
                        w_adv = 1'b1;
                    end else begin
                        n_valid   = 1'b1;
                        n_count   = COUNT_W'(w_reach);
                        n_sources = '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    w_ctl.grp = 1'b1;
                    n_state   = S_R_POP;
                end
            end
            S_R_POP: begin
                w_ctl.pop = 1'b1;
                w_rd_addr = w_sts.node;
                n_pops    = r_pops + CW'(1);
                n_state   = S_R_MERGE;
            end
            S_R_MERGE: begin
                w_ctl.merge = 1'b1;
                n_state     = S_R_GRP;
            end
            S_C_READ: begin
                w_rd_addr = r_v;
                n_state   = S_C_CHECK;
            end
            S_C_CHECK: begin
                if (|w_row) begin
                    w_ctl.init      = 1'b1;
                    w_ctl.init_node = r_v;
                    n_pops          = '0;
                    n_state         = S_R_GRP;
                end else begin
                    w_adv = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance the closure scan to the next node, or finish it
        if (w_adv) begin
            if (r_v == NW'(NODES - 1)) begin
                n_valid   = 1'b1;
                n_count   = n_sum;
                n_sources = n_tally;
                n_state   = S_IDLE;
            end else begin
                n_v     = r_v + NW'(1);
                n_state = S_C_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_reverse <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_reverse <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_closure <= n_closure;
        r_add     <= n_add;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_v       <= n_v;
        r_pops    <= n_pops;
        r_sum     <= n_sum;
        r_tally   <= n_tally;
        r_count   <= n_count;
        r_sources <= n_sources;
    end

endmodule
`default_nettype wire

### rtl/grc_adj_mem.sv
// Adjacency matrix storage: one row of out-edges per node, one port each way.
// Per-row valid bits make unwritten rows read as empty. Uses grc_pkg.
`default_nettype none
module grc_adj_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_wr_en,
    input  wire logic [grc_pkg::NW-1:0]    i_wr_addr,
    input  wire logic [grc_pkg::NODES-1:0] i_wr_data,
    input  wire logic [grc_pkg::NW-1:0]    i_rd_addr,
    output logic      [grc_pkg::NODES-1:0] o_rd_row
);
    import grc_pkg::*;

    logic [NODES-1:0] r_mem [NODES];
    logic [NODES-1:0] r_vld;
    logic [NODES-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

### rtl/grc_frontier.sv
// Visited and pending node sets of one reachability walk, with the
// two-step find-first that picks the next pending node. Uses grc_pkg.
`default_nettype none
module grc_frontier (
    input  wire logic                      i_clk,
    input  wire grc_pkg::t_front_ctl       i_ctl,
    input  wire logic [grc_pkg::NODES-1:0] i_row,
    output grc_pkg::t_front_sts            o_sts
);
    import grc_pkg::*;

    logic [NODES-1:0]    r_visited, n_visited;
    logic [NODES-1:0]    r_pending, n_pending;
    logic [GW-1:0]       r_grp, w_grp;
    logic [PW-1:0]       w_pend_pad;
    logic [NGRP-1:0]     w_grp_nz;
    logic [GRP_SIZE-1:0] w_grp_bits;
    logic [BW-1:0]       w_bit;
    logic [NW-1:0]       w_node;

    assign w_pend_pad = PW'(r_pending);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp_nz[g] = |w_pend_pad[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    always_comb begin
        w_grp = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (w_grp_nz[g]) begin
                w_grp = GW'(g);
            end
        end
    end

    // second step works on the group registered by the first
    assign w_grp_bits = w_pend_pad[{r_grp, BW'(0)} +: GRP_SIZE];

    always_comb begin
        w_bit = '0;
        for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (w_grp_bits[b]) begin
                w_bit = BW'(b);
            end
        end
    end

    assign w_node      = NW'({r_grp, w_bit});
    assign o_sts.empty = ~|w_grp_nz;
    assign o_sts.node  = w_node;

    always_comb begin
        n_visited = r_visited;
        n_pending = r_pending;
        if (i_ctl.init) begin
            n_visited = '0;
            n_pending = '0;
            n_visited[i_ctl.init_node] = 1'b1;
            n_pending[i_ctl.init_node] = 1'b1;
        end else if (i_ctl.pop) begin
            n_pending[w_node] = 1'b0;
        end else if (i_ctl.merge) begin
            n_visited = r_visited | i_row;
            n_pending = r_pending | (i_row & ~r_visited);
        end
    end

    always_ff @(posedge i_clk) begin
        r_visited <= n_visited;
        r_pending <= n_pending;
        if (i_ctl.grp) begin
            r_grp <= w_grp;
        end
    end

endmodule
`default_nettype wire
